// ===== rtl/core/ppm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types, codes and reset constants of the path pattern matcher.
// ----------------------------------------------------------------------------
package ppm_pkg;

    // Default store depths
    localparam int QUERY_DEPTH_DEFAULT = 64;
    localparam int PATH_DEPTH_DEFAULT  = 256;

    // Request opcodes
    localparam logic [2:0] OP_LOAD_QUERY  = 3'd0;
    localparam logic [2:0] OP_APPEND_PATH = 3'd1;
    localparam logic [2:0] OP_EVALUATE    = 3'd2;
    localparam logic [2:0] OP_RESTART     = 3'd3;
    localparam logic [2:0] OP_CLEAR_QUERY = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHILD      = 2'd0;
    localparam logic [1:0] CFG_DESCENDANT = 2'd1;
    localparam logic [1:0] CFG_SEPARATOR  = 2'd2;

    // Configuration reset values
    localparam logic [7:0] CHILD_SYMBOL_RESET      = 8'd1;
    localparam logic [7:0] DESCENDANT_SYMBOL_RESET = 8'd2;
    localparam logic [7:0] SEPARATOR_SYMBOL_RESET  = 8'd47;

    // Path terminator byte
    localparam logic [7:0] TERMINATOR = 8'd0;

    typedef enum logic [1:0] {
        VERDICT_MATCH      = 2'd0,
        VERDICT_MISMATCH   = 2'd1,
        VERDICT_INCOMPLETE = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
    } request_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       overflow_seen;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_RD,
        ST_STEP_EX,
        ST_TAIL_RD,
        ST_TAIL_EX,
        ST_DESC_RD,
        ST_DESC_EX
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load_query;
        logic     load_path;
        logic     restart;
        logic     clear_query;
        logic     tail_addr;
        logic     step;
        logic     tail_child;
        logic     desc_skip;
        logic     emit;
        verdict_t verdict;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_exit;
        logic walk_incomplete;
        logic walk_mismatch;
        logic desc_more;
        logic query_done;
    } status_t;

endpackage : ppm_pkg
`default_nettype wire

// ===== rtl/core/ppm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_ctrl
// Sequencer: dispatches requests and walks an evaluation through its
// read and execute phases.
// ----------------------------------------------------------------------------
module ppm_ctrl
    import ppm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [2:0] opcode,
    input  wire status_t    status,
    output logic            busy,
    output cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_EVALUATE)
                begin
                    state_next = ST_STEP_RD;
                end
            end
            ST_STEP_RD:
            begin
                state_next = ST_STEP_EX;
            end
            ST_STEP_EX:
            begin
                if (status.walk_exit)
                begin
                    state_next = status.walk_incomplete ? ST_IDLE : ST_TAIL_RD;
                end
                else if (status.walk_mismatch)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_STEP_RD;
                end
            end
            ST_TAIL_RD:
            begin
                state_next = ST_TAIL_EX;
            end
            ST_TAIL_EX:
            begin
                state_next = ST_DESC_RD;
            end
            ST_DESC_RD:
            begin
                state_next = ST_DESC_EX;
            end
            ST_DESC_EX:
            begin
                state_next = status.desc_more ? ST_DESC_RD : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd = '0;
        cmd.verdict = VERDICT_MATCH;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_query  = accept && (opcode == OP_LOAD_QUERY);
                cmd.load_path   = accept && (opcode == OP_APPEND_PATH);
                cmd.restart     = accept && (opcode == OP_RESTART);
                cmd.clear_query = accept && (opcode == OP_CLEAR_QUERY);
            end
            ST_STEP_EX:
            begin
                if (status.walk_exit)
                begin
                    if (status.walk_incomplete)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.verdict = VERDICT_INCOMPLETE;
                    end
                end
                else if (status.walk_mismatch)
                begin
                    cmd.emit    = 1'b1;
                    cmd.verdict = VERDICT_MISMATCH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_TAIL_RD:
            begin
                cmd.tail_addr = 1'b1;
            end
            ST_TAIL_EX:
            begin
                cmd.tail_addr  = 1'b1;
                cmd.tail_child = 1'b1;
            end
            ST_DESC_EX:
            begin
                if (status.desc_more)
                begin
                    cmd.desc_skip = 1'b1;
                end
                else
                begin
                    cmd.emit    = 1'b1;
                    cmd.verdict = status.query_done ? VERDICT_MATCH : VERDICT_MISMATCH;
                end
            end
            default:
            begin
                cmd = '0;
                cmd.verdict = VERDICT_MATCH;
            end
        endcase
    end

endmodule : ppm_ctrl
`default_nettype wire

// ===== rtl/core/ppm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_datapath
// Query and path stores, match cursors, backtrack point, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module ppm_datapath
    import ppm_pkg::*;
#(
    parameter int QUERY_DEPTH = QUERY_DEPTH_DEFAULT,
    parameter int PATH_DEPTH  = PATH_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire cmd_t       cmd,
    output status_t         status,
    output result_t         result,
    output logic            result_valid
);

    localparam int QA = $clog2(QUERY_DEPTH);
    localparam int QW = $clog2(QUERY_DEPTH + 1);
    localparam int PA = $clog2(PATH_DEPTH);
    localparam int PW = $clog2(PATH_DEPTH + 1);
    localparam logic [QW-1:0] QUERY_FULL = QW'(QUERY_DEPTH);
    localparam logic [PW-1:0] PATH_FULL  = PW'(PATH_DEPTH);

    logic [7:0] query_mem [QUERY_DEPTH];
    logic [7:0] path_mem  [PATH_DEPTH];

    logic [7:0]    child_symbol_reg;
    logic [7:0]    descendant_symbol_reg;
    logic [7:0]    separator_symbol_reg;

    logic [QW-1:0] query_length_reg, query_length_next;
    logic [PW-1:0] path_length_reg, path_length_next;
    logic [PW-1:0] path_cursor_reg, path_cursor_next;
    logic [QW-1:0] query_cursor_reg, query_cursor_next;
    logic [PW-1:0] bt_path_cursor_reg, bt_path_cursor_next;
    logic [QW-1:0] bt_query_cursor_reg, bt_query_cursor_next;
    logic          bt_valid_reg, bt_valid_next;
    logic          overflow_reg, overflow_next;
    result_t       result_reg;
    logic          result_valid_reg;

    logic [7:0]    path_rd_a;
    logic [7:0]    path_rd_b;
    logic [7:0]    query_rd;
    logic [PW-1:0] path_addr_a;

    logic query_ok;
    logic lit_hit;
    logic child_hit;
    logic desc_hit;
    logic prev_is_sep;
    logic write_query;
    logic write_path;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            child_symbol_reg      <= CHILD_SYMBOL_RESET;
            descendant_symbol_reg <= DESCENDANT_SYMBOL_RESET;
            separator_symbol_reg  <= SEPARATOR_SYMBOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHILD:      child_symbol_reg      <= cfg_data;
                CFG_DESCENDANT: descendant_symbol_reg <= cfg_data;
                CFG_SEPARATOR:  separator_symbol_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign write_query = cmd.load_query && (query_length_reg != QUERY_FULL);
    assign write_path  = cmd.load_path && (path_length_reg != PATH_FULL);

    // Query store: one write port, one registered read at the query cursor
    always_ff @(posedge clk)
    begin
        if (write_query)
        begin
            query_mem[query_length_reg[QA-1:0]] <= data_byte;
        end
        query_rd <= query_mem[query_cursor_reg[QA-1:0]];
    end

    // Select the cursor address, or the previous byte address for the end-of-path check
    assign path_addr_a = cmd.tail_addr ? (path_cursor_reg - PW'(1)) : path_cursor_reg;

    // Path store: one write port, reads at the cursor and the backtrack point
    always_ff @(posedge clk)
    begin
        if (write_path)
        begin
            path_mem[path_length_reg[PA-1:0]] <= data_byte;
        end
        path_rd_a <= path_mem[path_addr_a[PA-1:0]];
        path_rd_b <= path_mem[bt_path_cursor_reg[PA-1:0]];
    end

    // Classify the current walk step
    assign query_ok    = (query_cursor_reg < query_length_reg);
    assign lit_hit     = query_ok && (path_rd_a == query_rd);
    assign child_hit   = query_ok && (query_rd == child_symbol_reg);
    assign desc_hit    = query_ok && (query_rd == descendant_symbol_reg)
                         && (path_rd_a == separator_symbol_reg);
    assign prev_is_sep = (path_cursor_reg != '0) && (path_rd_a == separator_symbol_reg);

    always_comb
    begin
        status.walk_incomplete = (path_cursor_reg >= path_length_reg)
                                 || (bt_path_cursor_reg >= path_length_reg);
        status.walk_exit       = status.walk_incomplete || (path_rd_a == TERMINATOR);
        status.walk_mismatch   = !(lit_hit || child_hit || desc_hit || bt_valid_reg);
        status.desc_more       = query_ok && (query_rd == descendant_symbol_reg);
        status.query_done      = (query_cursor_reg == query_length_reg);
    end

    // Update lengths, cursors and backtrack point
    always_comb
    begin
        query_length_next    = query_length_reg;
        path_length_next     = path_length_reg;
        path_cursor_next     = path_cursor_reg;
        query_cursor_next    = query_cursor_reg;
        bt_path_cursor_next  = bt_path_cursor_reg;
        bt_query_cursor_next = bt_query_cursor_reg;
        bt_valid_next        = bt_valid_reg;
        overflow_next        = overflow_reg;

        if (cmd.load_query)
        begin
            if (write_query)
            begin
                query_length_next = query_length_reg + QW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end

        if (cmd.load_path)
        begin
            if (write_path)
            begin
                path_length_next = path_length_reg + PW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end

        if (cmd.step)
        begin
            if (lit_hit)
            begin
                path_cursor_next  = path_cursor_reg + PW'(1);
                query_cursor_next = query_cursor_reg + QW'(1);
            end
            else if (child_hit)
            begin
                if (path_rd_a == separator_symbol_reg)
                begin
                    query_cursor_next = query_cursor_reg + QW'(1);
                end
                else
                begin
                    path_cursor_next = path_cursor_reg + PW'(1);
                end
            end
            else if (desc_hit)
            begin
                bt_path_cursor_next  = path_cursor_reg + PW'(1);
                bt_query_cursor_next = query_cursor_reg;
                bt_valid_next        = 1'b1;
                query_cursor_next    = query_cursor_reg + QW'(1);
                path_cursor_next     = path_cursor_reg + PW'(1);
            end
            else
            begin
                // Stretch the descendant marker from the backtrack point
                if (path_rd_b == separator_symbol_reg)
                begin
                    path_cursor_next    = bt_path_cursor_reg + PW'(1);
                    query_cursor_next   = bt_query_cursor_reg + QW'(1);
                    bt_path_cursor_next = bt_path_cursor_reg + PW'(1);
                end
                else if (path_rd_b == TERMINATOR)
                begin
                    path_cursor_next  = bt_path_cursor_reg;
                    query_cursor_next = bt_query_cursor_reg + QW'(1);
                end
                else
                begin
                    bt_path_cursor_next = bt_path_cursor_reg + PW'(1);
                end
            end
        end

        // Let a trailing child wildcard complete unless the path ended right after a separator
        if (cmd.tail_child && child_hit && !prev_is_sep)
        begin
            query_cursor_next = query_cursor_reg + QW'(1);
        end

        if (cmd.desc_skip)
        begin
            query_cursor_next = query_cursor_reg + QW'(1);
        end

        if (cmd.restart || cmd.clear_query)
        begin
            path_cursor_next     = '0;
            query_cursor_next    = '0;
            bt_path_cursor_next  = '0;
            bt_query_cursor_next = '0;
            bt_valid_next        = 1'b0;
            overflow_next        = 1'b0;
        end

        if (cmd.restart)
        begin
            path_length_next = '0;
        end

        if (cmd.clear_query)
        begin
            query_length_next = '0;
        end
    end

    // Hold match state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg    <= '0;
            path_length_reg     <= '0;
            path_cursor_reg     <= '0;
            query_cursor_reg    <= '0;
            bt_path_cursor_reg  <= '0;
            bt_query_cursor_reg <= '0;
            bt_valid_reg        <= 1'b0;
            overflow_reg        <= 1'b0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            query_length_reg    <= query_length_next;
            path_length_reg     <= path_length_next;
            path_cursor_reg     <= path_cursor_next;
            query_cursor_reg    <= query_cursor_next;
            bt_path_cursor_reg  <= bt_path_cursor_next;
            bt_query_cursor_reg <= bt_query_cursor_next;
            bt_valid_reg        <= bt_valid_next;
            overflow_reg        <= overflow_next;
            result_valid_reg    <= cmd.emit;
        end
    end

    // Capture the result for one transfer
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.verdict       <= cmd.verdict;
            result_reg.overflow_seen <= overflow_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule : ppm_datapath
`default_nettype wire

// ===== rtl/core/path_pattern_matcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// path_pattern_matcher_unit
// Matches a stored byte path against a stored query pattern with child
// wildcards and descendant-or-self markers.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request transfers at a rising edge with start high
//   and busy low. Load query, append path, restart and clear query never
//   raise busy, and the next request may follow at once.
//   Evaluate raises busy while the walk runs. Each walk step is a store
//   read (STEP_RD), then the cursor update (STEP_EX); one step is spent per
//   path byte consumed, per wildcard closed at a separator and per backtrack
//   move. A walk that reaches the terminator adds the trailing wildcard
//   check (TAIL_RD, TAIL_EX), a DESC_RD/DESC_EX pass per trailing descendant
//   marker and one more for the closing check. The walk resumes from the
//   kept cursors, so repeated evaluates only cover newly appended bytes.
//   Result channel: the verdict and overflow flag appear for exactly one
//   cycle with result_valid high, in the first cycle with busy low again.
//   The receiver cannot stall the block.
//   Configuration: cfg_we writes cfg_data to register cfg_index at once.
//   Reset clears lengths, cursors, flags and restores the symbol defaults;
//   store contents are not cleared.
// ----------------------------------------------------------------------------
module path_pattern_matcher_unit
    import ppm_pkg::*;
#(
    parameter int QUERY_DEPTH = QUERY_DEPTH_DEFAULT,
    parameter int PATH_DEPTH  = PATH_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire request_t   request,
    output result_t         result,
    output logic            result_valid,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    // Sequence requests and evaluation phases
    ppm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Stores, cursors and result register
    ppm_datapath #(
        .QUERY_DEPTH (QUERY_DEPTH),
        .PATH_DEPTH  (PATH_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (request.data_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule : path_pattern_matcher_unit
`default_nettype wire

// ===== sim/path_pattern_matcher_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_pattern_matcher_unit_tb
// Self-checking bench for the path pattern matcher. A cycle-free predictor
// keeps its own copy of the query, the path, the walk cursors and the symbol
// registers, and queues the verdict of every accepted evaluate. A checker
// compares each strobed result field by field with the oldest queued verdict.
// Stimulus runs a short directed list, a store overflow pass, a sweep over
// symbol settings with random idle bursts, and a final stream without gaps.
// ----------------------------------------------------------------------------
module path_pattern_matcher_unit_tb;
    import ppm_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int QUERY_DEPTH   = QUERY_DEPTH_DEFAULT;
    localparam int PATH_DEPTH    = PATH_DEPTH_DEFAULT;
    localparam int QUERY_IDX_W   = $clog2(QUERY_DEPTH + 1);
    localparam int PATH_IDX_W    = $clog2(PATH_DEPTH + 1);
    localparam int QUERY_ADDR_W  = $clog2(QUERY_DEPTH);
    localparam int PATH_ADDR_W   = $clog2(PATH_DEPTH);
    // A full-length walk with heavy backtracking stays well below this
    localparam int STALL_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 40;

    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // Step names used to build paths and patterns
    localparam logic [7:0] NAME_A = 8'h61;
    localparam logic [7:0] NAME_B = 8'h62;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     start        = 1'b0;
    logic     busy;
    request_t request      = '0;
    result_t  result;
    logic     result_valid;
    logic       cfg_we     = 1'b0;
    logic [1:0] cfg_index  = CFG_CHILD;
    logic [7:0] cfg_data   = '0;

    // Predictor state
    logic [7:0]             query_mem [QUERY_DEPTH];
    logic [QUERY_IDX_W-1:0] query_len;
    logic [QUERY_IDX_W-1:0] query_cur;
    logic [QUERY_IDX_W-1:0] retry_query;
    logic [7:0]             path_mem [PATH_DEPTH];
    logic [PATH_IDX_W-1:0]  path_len;
    logic [PATH_IDX_W-1:0]  path_cur;
    logic [PATH_IDX_W-1:0]  retry_path;
    logic                   retry_ok;
    logic                   load_dropped;
    logic [7:0]             child_sym;
    logic [7:0]             desc_sym;
    logic [7:0]             sep_sym;

    result_t expected_verdicts[$];
    int      error_count  = 0;
    int      items_sent   = 0;
    int      gap_percent  = 25;
    int      stall_cycles = 0;

    path_pattern_matcher_unit #(
        .QUERY_DEPTH (QUERY_DEPTH),
        .PATH_DEPTH  (PATH_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Drop cursors, backtrack point and overflow flag
    function automatic void clear_walk_state();
        path_cur     = '0;
        query_cur    = '0;
        retry_path   = '0;
        retry_query  = '0;
        retry_ok     = 1'b0;
        load_dropped = 1'b0;
    endfunction

    // Resume the walk from the kept cursors and return the verdict
    function automatic verdict_t match_verdict();
        logic [7:0] pb;
        logic [7:0] qb;
        logic [7:0] bb;
        logic       q_ok;
        logic       prev_sep;
        while (path_cur < path_len && retry_path < path_len &&
               path_mem[PATH_ADDR_W'(path_cur)] != TERMINATOR) begin
            pb   = path_mem[PATH_ADDR_W'(path_cur)];
            q_ok = query_cur < query_len;
            qb   = q_ok ? query_mem[QUERY_ADDR_W'(query_cur)] : '0;
            if (q_ok && pb == qb) begin
                path_cur++;
                query_cur++;
            end else if (q_ok && qb == child_sym) begin
                // child wildcard stops at the separator
                if (pb == sep_sym)
                    query_cur++;
                else
                    path_cur++;
            end else if (q_ok && qb == desc_sym && pb == sep_sym) begin
                retry_path  = path_cur + 1'b1;
                retry_query = query_cur;
                retry_ok    = 1'b1;
                query_cur++;
                path_cur++;
            end else if (retry_ok) begin
                // stretch the descendant marker over one more byte
                bb = path_mem[PATH_ADDR_W'(retry_path)];
                if (bb == sep_sym) begin
                    path_cur    = retry_path + 1'b1;
                    query_cur   = retry_query + 1'b1;
                    retry_path++;
                end else if (bb == TERMINATOR) begin
                    path_cur  = retry_path;
                    query_cur = retry_query + 1'b1;
                end else begin
                    retry_path++;
                end
            end else begin
                return VERDICT_MISMATCH;
            end
        end

        if (path_cur >= path_len || retry_path >= path_len)
            return VERDICT_INCOMPLETE;

        // trailing wildcard, unless the path ended right after a separator
        if (query_cur < query_len && query_mem[QUERY_ADDR_W'(query_cur)] == child_sym) begin
            prev_sep = (path_cur > 0) &&
                       (path_mem[PATH_ADDR_W'(path_cur - 1'b1)] == sep_sym);
            if (!prev_sep)
                query_cur++;
        end
        while (query_cur < query_len && query_mem[QUERY_ADDR_W'(query_cur)] == desc_sym)
            query_cur++;
        return (query_cur == query_len) ? VERDICT_MATCH : VERDICT_MISMATCH;
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_name();
        if ($urandom_range(0, 9) == 0)
            return any_byte();
        return $urandom_range(0, 1) ? NAME_A : NAME_B;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    // Send one request, wait for its transfer, then update the predictor
    task automatic send_item(input logic [2:0] op, input logic [7:0] data);
        request_t req;
        result_t  res;
        req.opcode    = op;
        req.data_byte = data;
        if (gap_percent > 0 && $urandom_range(0, 99) < gap_percent) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do begin
            @(posedge clk);
        end while (busy);
        items_sent++;

        case (op)
            OP_LOAD_QUERY: begin
                if (query_len < QUERY_DEPTH) begin
                    query_mem[QUERY_ADDR_W'(query_len)] = data;
                    query_len++;
                end else begin
                    load_dropped = 1'b1;
                end
            end
            OP_APPEND_PATH: begin
                if (path_len < PATH_DEPTH) begin
                    path_mem[PATH_ADDR_W'(path_len)] = data;
                    path_len++;
                end else begin
                    load_dropped = 1'b1;
                end
            end
            OP_EVALUATE: begin
                res.verdict       = match_verdict();
                res.overflow_seen = load_dropped;
                expected_verdicts.push_back(res);
            end
            OP_RESTART: begin
                path_len = '0;
                clear_walk_state();
            end
            OP_CLEAR_QUERY: begin
                query_len = '0;
                clear_walk_state();
            end
            default: ;
        endcase
    endtask

    // Hold requests until every queued verdict has come back
    task automatic wait_results_drained(input int settle);
        if (expected_verdicts.size() != 0 || settle > 0)
            start <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write all three symbol registers while the block is idle
    task automatic write_symbols(input logic [7:0] child, input logic [7:0] desc,
                                 input logic [7:0] sep);
        wait_results_drained(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHILD;
        cfg_data  <= child;
        @(posedge clk);
        child_sym = child;
        cfg_index <= CFG_DESCENDANT;
        cfg_data  <= desc;
        @(posedge clk);
        desc_sym = desc;
        cfg_index <= CFG_SEPARATOR;
        cfg_data  <= sep;
        @(posedge clk);
        sep_sym = sep;
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed pattern/path sessions, some raw noise
    task automatic run_traffic(input int item_count, input bit allow_pauses);
        logic [7:0] pattern_bytes[$];
        logic [7:0] path_bytes[$];
        logic [2:0] op;
        int         n_steps;
        int         target;
        target = items_sent + item_count;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(3, 10)) begin
                    op = 3'($urandom_range(0, OP_UNUSED_LAST));
                    send_item(op, any_byte());
                end
            end else begin
                // fresh pattern: steps of separator or descendant, then a name or wildcard
                if (query_len == 0 || $urandom_range(0, 2) == 0) begin
                    pattern_bytes.delete();
                    n_steps = $urandom_range(0, 4);
                    repeat (n_steps) begin
                        pattern_bytes.push_back(($urandom_range(0, 3) == 0) ? desc_sym : sep_sym);
                        if ($urandom_range(0, 2) == 0)
                            pattern_bytes.push_back(child_sym);
                        else
                            repeat ($urandom_range(1, 2)) pattern_bytes.push_back(pick_name());
                    end
                    if ($urandom_range(0, 7) == 0)
                        pattern_bytes.push_back(desc_sym);
                    send_item(OP_CLEAR_QUERY, any_byte());
                    foreach (pattern_bytes[i])
                        send_item(OP_LOAD_QUERY, pattern_bytes[i]);
                end
                send_item(OP_RESTART, any_byte());

                path_bytes.delete();
                n_steps = $urandom_range(0, 5);
                repeat (n_steps) begin
                    path_bytes.push_back(sep_sym);
                    repeat ($urandom_range(1, 2)) path_bytes.push_back(pick_name());
                end
                // evaluate part way through to exercise resumed walks
                foreach (path_bytes[i]) begin
                    send_item(OP_APPEND_PATH, path_bytes[i]);
                    if ($urandom_range(0, 6) == 0)
                        send_item(OP_EVALUATE, any_byte());
                end
                if ($urandom_range(0, 9) != 0)
                    send_item(OP_APPEND_PATH, TERMINATOR);
                send_item(OP_EVALUATE, any_byte());
                if ($urandom_range(0, 3) == 0) begin
                    send_item(OP_APPEND_PATH, pick_name());
                    send_item(OP_EVALUATE, any_byte());
                end
            end
            if (allow_pauses && $urandom_range(0, 24) == 0)
                wait_results_drained(0);
        end
    endtask

    // Literals, wildcard, backtracking, resume and the position-zero case
    task automatic test_directed_cases();
        send_item(OP_EVALUATE, 8'hFF);
        send_item(OP_UNUSED_LAST, 8'hFF);
        send_item(OP_LOAD_QUERY, SEPARATOR_SYMBOL_RESET);
        send_item(OP_LOAD_QUERY, NAME_A);
        send_item(OP_LOAD_QUERY, SEPARATOR_SYMBOL_RESET);
        send_item(OP_LOAD_QUERY, CHILD_SYMBOL_RESET);
        send_item(OP_APPEND_PATH, SEPARATOR_SYMBOL_RESET);
        send_item(OP_APPEND_PATH, NAME_A);
        send_item(OP_EVALUATE, 8'h00);
        send_item(OP_APPEND_PATH, SEPARATOR_SYMBOL_RESET);
        send_item(OP_APPEND_PATH, NAME_B);
        send_item(OP_APPEND_PATH, TERMINATOR);
        send_item(OP_EVALUATE, 8'h00);
        send_item(OP_EVALUATE, 8'h00);
        // descendant marker has to backtrack past the first step
        send_item(OP_CLEAR_QUERY, 8'h00);
        send_item(OP_LOAD_QUERY, DESCENDANT_SYMBOL_RESET);
        send_item(OP_LOAD_QUERY, NAME_B);
        send_item(OP_EVALUATE, 8'h00);
        // wildcard against an empty path
        send_item(OP_RESTART, 8'h00);
        send_item(OP_CLEAR_QUERY, 8'hFF);
        send_item(OP_LOAD_QUERY, CHILD_SYMBOL_RESET);
        send_item(OP_APPEND_PATH, TERMINATOR);
        send_item(OP_EVALUATE, 8'h00);
        send_item(OP_LOAD_QUERY, 8'h00);
        send_item(OP_EVALUATE, 8'hFF);
    endtask

    // Fill both stores past their depth and check the flag and its clearing
    task automatic test_store_overflow();
        logic [7:0] b;
        send_item(OP_RESTART, any_byte());
        send_item(OP_CLEAR_QUERY, any_byte());
        repeat (QUERY_DEPTH + 3) begin
            case ($urandom_range(0, 5))
                0:       b = sep_sym;
                1:       b = desc_sym;
                2:       b = child_sym;
                default: b = pick_name();
            endcase
            send_item(OP_LOAD_QUERY, b);
        end
        for (int i = 0; i < PATH_DEPTH - 1; i++) begin
            send_item(OP_APPEND_PATH, (i % 3 == 0) ? sep_sym : pick_name());
            if (i == PATH_DEPTH / 3)
                send_item(OP_EVALUATE, any_byte());
        end
        send_item(OP_APPEND_PATH, TERMINATOR);
        repeat (3) send_item(OP_APPEND_PATH, any_byte());
        send_item(OP_EVALUATE, any_byte());
        send_item(OP_CLEAR_QUERY, any_byte());
        send_item(OP_LOAD_QUERY, sep_sym);
        send_item(OP_LOAD_QUERY, child_sym);
        send_item(OP_EVALUATE, any_byte());
        send_item(OP_APPEND_PATH, any_byte());
        send_item(OP_EVALUATE, any_byte());
        send_item(OP_RESTART, any_byte());
        send_item(OP_EVALUATE, any_byte());
    endtask

    // Walk through symbol settings, extremes first, with and without gaps
    task automatic test_symbol_sweep();
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] s;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin c = 8'h00; d = 8'h00; s = 8'h00; end
                1: begin c = 8'hFF; d = 8'hFF; s = 8'hFF; end
                2: begin c = 8'h00; d = 8'hFF; s = SEPARATOR_SYMBOL_RESET; end
                3: begin c = 8'hFF; d = 8'h00; s = 8'h00; end
                7: begin
                    c = CHILD_SYMBOL_RESET;
                    d = DESCENDANT_SYMBOL_RESET;
                    s = SEPARATOR_SYMBOL_RESET;
                end
                default: begin c = any_byte(); d = any_byte(); s = any_byte(); end
            endcase
            gap_percent = phase[0] ? 0 : 30;
            write_symbols(c, d, s);
            run_traffic(75, 1'b1);
            wait_results_drained(0);
            run_traffic(75, 1'b1);
        end
    endtask

    // Back-to-back requests at the reset symbols
    task automatic test_steady_stream();
        write_symbols(CHILD_SYMBOL_RESET, DESCENDANT_SYMBOL_RESET, SEPARATOR_SYMBOL_RESET);
        gap_percent = 0;
        run_traffic(280, 1'b0);
    endtask

    // Check each strobed result against the oldest queued verdict
    always @(posedge clk) begin : check_results
        result_t want;
        if (rst_n && result_valid) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected result, verdict", '0, 8'(result.verdict));
            end else begin
                want = expected_verdicts.pop_front();
                if (result.verdict !== want.verdict)
                    report_mismatch("verdict", 8'(want.verdict), 8'(result.verdict));
                if (result.overflow_seen !== want.overflow_seen)
                    report_mismatch("overflow_seen", 8'(want.overflow_seen),
                                    8'(result.overflow_seen));
            end
        end
    end

    // End the run when nothing transfers for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL path_pattern_matcher_unit");
                $finish;
            end
        end
    end

    initial begin
        child_sym = CHILD_SYMBOL_RESET;
        desc_sym  = DESCENDANT_SYMBOL_RESET;
        sep_sym   = SEPARATOR_SYMBOL_RESET;
        query_len = '0;
        path_len  = '0;
        clear_walk_state();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_store_overflow();
        test_symbol_sweep();
        test_steady_stream();

        wait_results_drained(SETTLE_CYCLES * 4);
        if (error_count == 0)
            $display("PASS path_pattern_matcher_unit");
        else
            $display("FAIL path_pattern_matcher_unit");
        $finish;
    end

endmodule
